### sv/delay_wakeup_timer_table_defines.svh
// ----------------------------------------------------------------------------
// Delay wakeup timer table: assertion macros
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef DELAY_WAKEUP_TIMER_TABLE_DEFINES_SVH
`define DELAY_WAKEUP_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define DWT_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWT_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg
// Transaction types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dwt_pkg;

	localparam int MS_WRAP  = 1000;
	localparam int SEC_WRAP = 60;

	localparam logic [1:0] OP_DELAY = 2'd0;
	localparam logic [1:0] OP_TIME  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_TIME   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;
	localparam logic [1:0] KIND_WAKE   = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  requester_id;
		logic [30:0] delay_ticks;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [7:0]  target_id;
		logic [9:0]  millis;
		logic [5:0]  seconds;
		logic [15:0] minutes;
		logic        last_of_run;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_FLUSH
	} ctrl_state_t;

	// what the latched request needs
	typedef enum logic [1:0] {
		CLS_DROP,
		CLS_PUSH,
		CLS_REPLY,
		CLS_TICK
	} op_class_t;

	typedef struct packed {
		logic latch_in;
		logic push;
		logic emit;
		logic start_tick;
		logic scan_step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		op_class_t op_class;
		logic      out_free;
		logic      issue_done;
		logic      s1_valid;
		logic      s1_wake;
	} status_t;

endpackage

`default_nettype wire

### sv/dwt_ctrl.sv
// ----------------------------------------------------------------------------
// dwt_ctrl
// Sequencer: accepts one request, dispatches it, runs the slot scan on ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module dwt_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  dwt_pkg::status_t st,
	output dwt_pkg::cmd_t   cmd
);
	import dwt_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        scan_hold;

	// a wake can only leave s1 when the output register can take the held result
	assign scan_hold = st.s1_valid && st.s1_wake && !st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (st.op_class)
					CLS_DROP:  state_nxt = ST_IDLE;
					CLS_PUSH:  state_nxt = ST_IDLE;
					CLS_REPLY: if (st.out_free) state_nxt = ST_IDLE;
					CLS_TICK:  state_nxt = ST_SCAN;
					default:   state_nxt = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (st.issue_done && !st.s1_valid) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				cmd.latch_in = req_valid;
			end
			ST_DISPATCH: begin
				cmd.push       = st.op_class == CLS_PUSH;
				cmd.emit       = st.op_class == CLS_REPLY && st.out_free;
				cmd.start_tick = st.op_class == CLS_TICK;
			end
			ST_SCAN: begin
				cmd.scan_step = !scan_hold;
			end
			ST_FLUSH: begin
				cmd.flush = st.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/dwt_datapath.sv
// ----------------------------------------------------------------------------
// dwt_datapath
// Clock counters, slot memories, free-slot stack, scan stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwt_datapath #(
	parameter int SLOTS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  dwt_pkg::cmd_t      cmd,
	output dwt_pkg::status_t   st,
	input  dwt_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output dwt_pkg::rsp_item_t rsp
);
	import dwt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// slot memories and free stack
	logic [7:0]       owner_mem [SLOTS];
	logic [30:0]      rem_mem   [SLOTS];
	logic [IDX_W-1:0] fs_mem    [SLOTS];

	req_item_t        in_q;
	logic [9:0]       ms_q;
	logic [5:0]       sec_q;
	logic [15:0]      min_q;
	logic [CNT_W-1:0] used_q;
	logic [SLOTS-1:0] occ_q;
	logic [SLOTS-1:0] fs_vld_q;
	logic [IDX_W-1:0] fs_rd_q;
	logic             fs_rd_vld_q;

	logic [CNT_W-1:0] issue_q;
	logic             s1_valid;
	logic             occ_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0]       owner_s1;
	logic [30:0]      rem_s1;

	logic [1:0]       pend_kind_q;
	logic [7:0]       pend_id_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic             full;
	logic             issue_done;
	logic             read_en;
	logic             s1_live;
	logic             wake_do;
	logic [IDX_W-1:0] push_slot;
	logic [IDX_W-1:0] used_idx;
	logic [CNT_W-1:0] used_dec;
	logic [IDX_W-1:0] issue_idx;
	logic             rem_we;
	logic [IDX_W-1:0] rem_waddr;
	logic [30:0]      rem_wdata;
	logic             out_free;
	op_class_t        op_class;

	assign full       = used_q == CNT_W'(SLOTS);
	assign issue_done = issue_q == CNT_W'(SLOTS);
	assign issue_idx  = issue_q[IDX_W-1:0];
	assign used_idx   = used_q[IDX_W-1:0];
	assign used_dec   = used_q - CNT_W'(1);
	assign read_en    = cmd.scan_step && !issue_done;
	assign s1_live    = cmd.scan_step && s1_valid && occ_s1;
	assign wake_do    = s1_live && rem_s1 == 31'd1;
	// a never-written stack entry is taken to hold its own index
	assign push_slot  = fs_rd_vld_q ? fs_rd_q : used_idx;
	assign out_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (in_q.requester_id == 8'd0) begin
			op_class = CLS_DROP;
		end else begin
			case (in_q.operation)
				OP_DELAY: op_class = (in_q.delay_ticks == 31'd0 || full) ? CLS_REPLY : CLS_PUSH;
				OP_TIME:  op_class = CLS_REPLY;
				OP_TICK:  op_class = CLS_TICK;
				default:  op_class = CLS_DROP;
			endcase
		end
	end

	always_comb begin
		st            = '0;
		st.op_class   = op_class;
		st.out_free   = out_free;
		st.issue_done = issue_done;
		st.s1_valid   = s1_valid;
		st.s1_wake    = occ_s1 && rem_s1 == 31'd1;
	end

	always_comb begin
		rem_we    = cmd.push || s1_live;
		rem_waddr = cmd.push ? push_slot : idx_s1;
		rem_wdata = cmd.push ? in_q.delay_ticks : rem_s1 - 31'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) in_q <= req;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) owner_mem[push_slot] <= in_q.requester_id;
		if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
		if (wake_do) fs_mem[used_dec[IDX_W-1:0]] <= idx_s1;
		fs_rd_q <= fs_mem[used_idx];
		if (read_en) begin
			owner_s1 <= owner_mem[issue_idx];
			rem_s1   <= rem_mem[issue_idx];
			idx_s1   <= issue_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q  <= '0;
			sec_q <= '0;
			min_q <= '0;
		end else if (cmd.start_tick) begin
			if (ms_q == 10'(MS_WRAP - 1)) begin
				ms_q <= '0;
				if (sec_q == 6'(SEC_WRAP - 1)) begin
					sec_q <= '0;
					min_q <= min_q + 16'd1;
				end else begin
					sec_q <= sec_q + 6'd1;
				end
			end else begin
				ms_q <= ms_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			occ_q       <= '0;
			fs_vld_q    <= '0;
			fs_rd_vld_q <= 1'b0;
		end else begin
			fs_rd_vld_q <= fs_vld_q[used_idx];
			if (cmd.push) begin
				used_q           <= used_q + CNT_W'(1);
				occ_q[push_slot] <= 1'b1;
			end else if (wake_do) begin
				used_q                      <= used_dec;
				occ_q[idx_s1]               <= 1'b0;
				fs_vld_q[used_dec[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= '0;
			s1_valid <= 1'b0;
			occ_s1   <= 1'b0;
		end else if (cmd.start_tick) begin
			issue_q  <= '0;
			s1_valid <= 1'b0;
		end else if (cmd.scan_step) begin
			s1_valid <= !issue_done;
			if (read_en) begin
				issue_q <= issue_q + CNT_W'(1);
				occ_s1  <= occ_q[issue_idx];
			end
		end
	end

	// one result is held back so the last of a tick's run can be marked
	always_ff @(posedge clk) begin
		if (cmd.start_tick) begin
			pend_kind_q <= KIND_ACK;
			pend_id_q   <= in_q.requester_id;
		end else if (wake_do) begin
			pend_kind_q <= KIND_WAKE;
			pend_id_q   <= owner_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.flush || wake_do) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.target_id   <= in_q.requester_id;
			rsp_q.last_of_run <= 1'b1;
			if (in_q.operation == OP_TIME) begin
				rsp_q.reply_kind <= KIND_TIME;
				rsp_q.millis     <= ms_q;
				rsp_q.seconds    <= sec_q;
				rsp_q.minutes    <= min_q;
			end else begin
				rsp_q.reply_kind <= KIND_REJECT;
				rsp_q.millis     <= '0;
				rsp_q.seconds    <= '0;
				rsp_q.minutes    <= '0;
			end
		end else if (cmd.flush || wake_do) begin
			rsp_q.reply_kind  <= pend_kind_q;
			rsp_q.target_id   <= pend_id_q;
			rsp_q.millis      <= '0;
			rsp_q.seconds     <= '0;
			rsp_q.minutes     <= '0;
			rsp_q.last_of_run <= cmd.flush;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### sv/delay_wakeup_timer_table.sv
// ----------------------------------------------------------------------------
// delay_wakeup_timer_table
// Multi-slot delay timer with a time-of-day counter.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries delay, get-time and tick
//   requests; rsp channel (rsp_valid/rsp_stall/rsp) returns acknowledges,
//   time replies, rejections and wakes. last_of_run flags the final result
//   of each request.
//   One request is worked on at a time. A delay request gives no result
//   unless rejected; a get-time reply or a rejection is loaded from the
//   latched request into the output register once that register is free,
//   and the next request is taken after it. A tick's last result is loaded
//   as the block goes back to idle; the scan walks the slot memories through
//   a single read port, one slot per cycle unless a wake waits to go out.
//   Results pass through one output register; while rsp_stall is high the
//   register holds and the scan pauses at the next wake, and req_stall
//   stays high until the request in work is finished.
//   Reset clears the clock, empties every slot and restores the free stack;
//   the block comes out of reset idle and ready to take a request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delay_wakeup_timer_table_defines.svh"

module delay_wakeup_timer_table #(
	parameter int SLOTS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  dwt_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output dwt_pkg::rsp_item_t rsp
);
	import dwt_pkg::*;

	cmd_t    cmd;
	status_t st;

	dwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	dwt_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`DWT_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall, "request accepted while another is in work")
	`DWT_ASSERT_IMP(a_wake_has_room, clk, arst_n, cmd.scan_step && st.s1_valid && st.s1_wake, st.out_free, "wake overwrote an undelivered result")
	`DWT_ASSERT_IMP(a_single_load, clk, arst_n, 1'b1, $onehot0({cmd.emit, cmd.flush, cmd.scan_step && st.s1_valid && st.s1_wake}), "two output loads in one cycle")

endmodule

`default_nettype wire

### tb/delay_wakeup_timer_table_tb.sv
// ----------------------------------------------------------------------------
// delay_wakeup_timer_table_tb
// Drives delay, get-time and tick requests into the timer table, tracks slot
// occupancy and time of day in a local predictor, and checks every reply and
// wake in order, with random request gaps and random reply backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_wakeup_timer_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dwt_pkg::*;

	localparam int SLOTS = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [30:0] TICKS_MAX = 31'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;

	delay_wakeup_timer_table #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// predicted state of the timer table
	logic [9:0]  clock_ms;
	logic [5:0]  clock_sec;
	logic [15:0] clock_min;
	logic [7:0]  owner_of [SLOTS];
	logic [30:0] ticks_left [SLOTS];
	logic [4:0]  free_slots [SLOTS];
	logic [5:0]  slots_in_use;

	rsp_item_t pending_replies [$];
	int mismatch_count = 0;
	bit sender_gaps = 1'b1;
	bit receiver_gaps = 1'b1;
	int hold_left = 0;

	task automatic clear_timer_state();
		clock_ms = '0;
		clock_sec = '0;
		clock_min = '0;
		for (int s = 0; s < SLOTS; s++) begin
			owner_of[s] = '0;
			ticks_left[s] = '0;
			free_slots[s] = 5'(s);
		end
		slots_in_use = '0;
	endtask

	// expected replies and wakes for one accepted transaction
	task automatic predict_replies(input req_item_t item);
		rsp_item_t held;
		logic [4:0] slot;
		if (item.requester_id == 8'd0)
			return;
		held = '0;
		held.target_id = item.requester_id;
		held.last_of_run = 1'b1;
		case (item.operation)
		OP_DELAY: begin
			if (item.delay_ticks == '0 || slots_in_use >= 6'(SLOTS)) begin
				held.reply_kind = KIND_REJECT;
				pending_replies.push_back(held);
			end else begin
				slot = free_slots[slots_in_use];
				slots_in_use++;
				owner_of[slot] = item.requester_id;
				ticks_left[slot] = item.delay_ticks;
			end
		end
		OP_TIME: begin
			held.reply_kind = KIND_TIME;
			held.millis = clock_ms;
			held.seconds = clock_sec;
			held.minutes = clock_min;
			pending_replies.push_back(held);
		end
		OP_TICK: begin
			held.reply_kind = KIND_ACK;
			held.last_of_run = 1'b0;
			if (clock_ms == 10'(MS_WRAP - 1)) begin
				clock_ms = '0;
				if (clock_sec == 6'(SEC_WRAP - 1)) begin
					clock_sec = '0;
					clock_min++;
				end else begin
					clock_sec++;
				end
			end else begin
				clock_ms++;
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (owner_of[s] != 8'd0) begin
					ticks_left[s]--;
					if (ticks_left[s] == '0) begin
						pending_replies.push_back(held);
						held = '0;
						held.reply_kind = KIND_WAKE;
						held.target_id = owner_of[s];
						owner_of[s] = '0;
						slots_in_use--;
						free_slots[slots_in_use] = 5'(s);
					end
				end
			end
			held.last_of_run = 1'b1;
			pending_replies.push_back(held);
		end
		default: ;
		endcase
	endtask

	function automatic req_item_t make_item(logic [1:0] op, logic [7:0] id,
			logic [30:0] ticks);
		req_item_t item;
		item.operation = op;
		item.requester_id = id;
		item.delay_ticks = ticks;
		return item;
	endfunction

	function automatic logic [7:0] any_id();
		return 8'($urandom_range(1, 255));
	endfunction

	// mostly short waits so slots expire; now and then a huge one
	function automatic logic [30:0] pick_delay();
		if ($urandom_range(99) < 3)
			return 31'($urandom());
		return 31'($urandom_range(1, 12));
	endfunction

	task automatic send_request(input req_item_t item);
		@(negedge clk);
		while (sender_gaps && $urandom_range(99) < 26) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		predict_replies(item);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			rsp_stall <= receiver_gaps && ($urandom_range(99) < 26);
		end
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : reply_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				compare_field("reply_kind", 32'(want.reply_kind), 32'(rsp.reply_kind));
				compare_field("target_id", 32'(want.target_id), 32'(rsp.target_id));
				compare_field("millis", 32'(want.millis), 32'(rsp.millis));
				compare_field("seconds", 32'(want.seconds), 32'(rsp.seconds));
				compare_field("minutes", 32'(want.minutes), 32'(rsp.minutes));
				compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp.last_of_run));
			end
		end
	end

	// every operation, ignored ids and codes, zero delay
	task automatic test_basic_ops();
		send_request(make_item(OP_TIME, 8'hFF, '0));
		send_request(make_item(OP_TICK, 8'h55, TICKS_MAX));
		send_request(make_item(OP_UNUSED, 8'h07, 31'd1));
		send_request(make_item(OP_TICK, 8'h00, 31'd1));
		send_request(make_item(OP_DELAY, 8'h00, 31'd1));
		send_request(make_item(OP_TIME, 8'h00, '0));
		send_request(make_item(OP_DELAY, 8'hAA, '0));
		send_request(make_item(OP_DELAY, 8'h01, 31'd1));
		send_request(make_item(OP_TICK, 8'h80, '0));
		send_request(make_item(OP_TIME, 8'h01, '0));
	endtask

	// several wakes in one tick come out in slot order; a freed slot is reused
	task automatic test_wake_order();
		send_request(make_item(OP_DELAY, 8'h11, 31'd2));
		send_request(make_item(OP_DELAY, 8'h22, 31'd1));
		send_request(make_item(OP_DELAY, 8'h33, 31'd2));
		send_request(make_item(OP_TICK, 8'h44, '0));
		send_request(make_item(OP_DELAY, 8'h66, 31'd1));
		send_request(make_item(OP_TICK, 8'h44, '0));
	endtask

	// fill every slot, overflow, then two ticks; the second wakes them all
	task automatic test_table_full();
		wait_for_drain();
		for (int n = 0; n < SLOTS; n++)
			send_request(make_item(OP_DELAY, any_id(), 31'd2));
		send_request(make_item(OP_DELAY, 8'hC3, 31'd5));
		send_request(make_item(OP_TICK, any_id(), '0));
		send_request(make_item(OP_TICK, any_id(), '0));
		send_request(make_item(OP_TIME, 8'h3C, '0));
	endtask

	task automatic test_extreme_delay();
		send_request(make_item(OP_DELAY, 8'hFF, TICKS_MAX));
		send_request(make_item(OP_TICK, 8'h01, '0));
	endtask

	task automatic test_backpressure();
		wait_for_drain();
		hold_left = 300;
		for (int n = 0; n < 10; n++)
			send_request(make_item(OP_DELAY, any_id(), 31'($urandom_range(1, 2))));
		for (int n = 0; n < 6; n++)
			send_request(make_item(OP_TICK, any_id(), '0));
		wait_for_drain();
	endtask

	task automatic test_random_mix(input int count);
		int done;
		int roll;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				send_request(make_item(OP_DELAY, any_id(), pick_delay()));
				done++;
			end else if (roll < 55) begin
				send_request(make_item(OP_TIME, any_id(), 31'($urandom())));
				done++;
			end else if (roll < 94) begin
				send_request(make_item(OP_TICK, any_id(), 31'($urandom())));
				done++;
			end else if (roll < 97) begin
				send_request(make_item(OP_UNUSED, any_id(), 31'($urandom())));
			end else begin
				send_request(make_item(2'($urandom_range(3)), 8'h00, 31'($urandom())));
			end
			if ($urandom_range(99) == 0)
				wait_for_drain();
		end
	endtask

	// long stretch with no idling on either side
	task automatic test_no_gaps();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		for (int n = 0; n < 40; n++) begin
			if (n % 4 == 1)
				send_request(make_item(OP_DELAY, any_id(), 31'($urandom_range(1, 6))));
			else
				send_request(make_item(OP_TICK, any_id(), '0));
		end
		send_request(make_item(OP_TIME, 8'h5A, '0));
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	initial begin
		clear_timer_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_basic_ops();
		test_wake_order();
		test_table_full();
		test_extreme_delay();
		test_backpressure();
		test_random_mix(130);
		test_no_gaps();
		test_random_mix(10);
		wait_for_drain();
		repeat (SLOTS + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/dwt_pkg.sv
sv/dwt_ctrl.sv
sv/dwt_datapath.sv
sv/delay_wakeup_timer_table.sv
tb/delay_wakeup_timer_table_tb.sv
